// File: rtl/fks_pkg.sv
// fks_pkg: widths, state codes and control structs of the fitness key sorter
// used by fks_ctrl, fks_datapath, fitness_key_sorter and fks_checker
package fks_pkg;

   localparam int KEY_W  = 48;
   localparam int TAG_W  = 8;
   localparam int DATA_W = KEY_W + TAG_W;

   typedef enum logic [1:0] {
      ST_LOAD  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

   typedef struct packed {
      logic insert;
      logic set_ovf;
      logic shift_out;
      logic clear_ovf;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic one_left;
   } status_type;

endpackage

// File: rtl/fks_ctrl.sv
// fks_ctrl: load/drain state machine, handshakes and datapath commands
// depends on fks_pkg
module fks_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tlast,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  fks_pkg::status_type status,
   output fks_pkg::cmd_type    cmd
);

   fks_pkg::state_type state_ff, state_in;
   logic req_fire, rsp_fire;

   assign req_tready = (state_ff == fks_pkg::ST_LOAD);
   assign rsp_tvalid = (state_ff == fks_pkg::ST_DRAIN);
   assign req_fire   = req_tvalid & req_tready;
   assign rsp_fire   = rsp_tvalid & rsp_tready;

   assign cmd.insert    = req_fire & ~status.full;
   assign cmd.set_ovf   = req_fire & status.full;
   assign cmd.shift_out = rsp_fire;
   assign cmd.clear_ovf = rsp_fire & status.one_left;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fks_pkg::ST_LOAD: begin
            if (req_fire && req_tlast) state_in = fks_pkg::ST_DRAIN;
         end
         fks_pkg::ST_DRAIN: begin
            if (rsp_fire && status.one_left) state_in = fks_pkg::ST_LOAD;
         end
         default: state_in = fks_pkg::ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fks_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/fks_datapath.sv
// fks_datapath: insertion chain of sorted key/tag cells, fill count, overflow flag
// depends on fks_pkg; driven by fks_ctrl commands
module fks_datapath #(
   parameter int MAX_ELEMENTS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  fks_pkg::cmd_type                  cmd,
   input  logic signed [fks_pkg::KEY_W-1:0]  in_key,
   input  logic        [fks_pkg::TAG_W-1:0]  in_tag,
   output logic signed [fks_pkg::KEY_W-1:0]  head_key,
   output logic        [fks_pkg::TAG_W-1:0]  head_tag,
   output logic                              overflow,
   output fks_pkg::status_type               status
);

   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

   logic signed [fks_pkg::KEY_W-1:0] key_ff [MAX_ELEMENTS];
   logic        [fks_pkg::TAG_W-1:0] tag_ff [MAX_ELEMENTS];
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic [MAX_ELEMENTS-1:0] gt;

   // a cell moves up when it is empty or holds a strictly greater key
   always_comb begin
      for (int i = 0; i < MAX_ELEMENTS; i++) begin
         gt[i] = (CNT_W'(i) >= count_ff) || (key_ff[i] > in_key);
      end
   end

   for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
      logic signed [fks_pkg::KEY_W-1:0] prev_key, next_key;
      logic        [fks_pkg::TAG_W-1:0] prev_tag, next_tag;
      logic                             prev_gt;

      if (i == 0) begin : g_first
         assign prev_key = in_key;
         assign prev_tag = in_tag;
         assign prev_gt  = 1'b0;
      end else begin : g_rest
         assign prev_key = key_ff[i-1];
         assign prev_tag = tag_ff[i-1];
         assign prev_gt  = gt[i-1];
      end

      if (i == MAX_ELEMENTS - 1) begin : g_top
         assign next_key = key_ff[i];
         assign next_tag = tag_ff[i];
      end else begin : g_mid
         assign next_key = key_ff[i+1];
         assign next_tag = tag_ff[i+1];
      end

      always_ff @(posedge clock) begin
         if (cmd.insert && gt[i]) begin
            key_ff[i] <= prev_gt ? prev_key : in_key;
            tag_ff[i] <= prev_gt ? prev_tag : in_tag;
         end else if (cmd.shift_out) begin
            key_ff[i] <= next_key;
            tag_ff[i] <= next_tag;
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (cmd.insert)    count_in = count_ff + CNT_W'(1);
      if (cmd.shift_out) count_in = count_ff - CNT_W'(1);
      if (cmd.set_ovf)   ovf_in = 1'b1;
      if (cmd.clear_ovf) ovf_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   assign head_key        = key_ff[0];
   assign head_tag        = tag_ff[0];
   assign overflow        = ovf_ff;
   assign status.full     = (count_ff == CNT_W'(MAX_ELEMENTS));
   assign status.one_left = (count_ff == CNT_W'(1));

endmodule

// File: rtl/fitness_key_sorter.sv
// fitness_key_sorter: stable ascending sort of up to MAX_ELEMENTS keyed, tagged items
// loading accepts one item per cycle outside the drain; the insertion chain places each key on arrival
// the first result is offered the cycle after the tlast transfer, then one per cycle while rsp_tready is high
// no loading during the drain
// reset clears state, fill count and overflow flag; cell contents are not cleared
// depends on fks_pkg, fks_ctrl, fks_datapath
module fitness_key_sorter #(
   parameter int MAX_ELEMENTS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [fks_pkg::DATA_W-1:0]  req_tdata,   // key, tag
   input  logic                        req_tlast,   // is_last
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [fks_pkg::DATA_W-1:0]  rsp_tdata,   // sorted_key, sorted_tag
   output logic                        rsp_tlast,   // final_res
   output logic                        rsp_tuser    // overflow
);

   fks_pkg::cmd_type    cmd;
   fks_pkg::status_type status;
   logic signed [fks_pkg::KEY_W-1:0] head_key;
   logic        [fks_pkg::TAG_W-1:0] head_tag;

   fks_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   fks_datapath #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .in_key   (req_tdata[fks_pkg::KEY_W-1:0]),
      .in_tag   (req_tdata[fks_pkg::DATA_W-1:fks_pkg::KEY_W]),
      .head_key (head_key),
      .head_tag (head_tag),
      .overflow (rsp_tuser),
      .status   (status)
   );

   assign rsp_tdata = {head_tag, head_key};
   assign rsp_tlast = status.one_left;

endmodule

// File: rtl/fks_checker.sv
// fks_checker: port-level checks of the fitness key sorter, bound to the top level
// depends on fks_pkg and fitness_key_sorter
module fks_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tvalid,
   input logic                        req_tready,
   input logic                        req_tlast,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [fks_pkg::DATA_W-1:0]  rsp_tdata,
   input logic                        rsp_tlast,
   input logic                        rsp_tuser
);

   logic req_fire, rsp_fire;

   assign req_fire = req_tvalid & req_tready;
   assign rsp_fire = rsp_tvalid & rsp_tready;

   // loading and draining never overlap
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input ready while results are offered");

   // the run starts right after the closing transfer
   a_run_starts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tlast) |=> rsp_tvalid)
      else $error("no result after closing transfer");

   // the run ends with the tlast transfer
   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_tlast) |=> (!rsp_tvalid && req_tready))
      else $error("results continue after final transfer");

   // keys leave in ascending signed order, overflow flag constant over the run
   a_ascending: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && !rsp_tlast) |=>
         (rsp_tvalid && $stable(rsp_tuser) &&
          ($signed(rsp_tdata[fks_pkg::KEY_W-1:0]) >=
           $signed($past(rsp_tdata[fks_pkg::KEY_W-1:0])))))
      else $error("keys out of order within a run");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("stalled result changed");

endmodule

bind fitness_key_sorter fks_checker u_fks_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

// File: dv/tb_fitness_key_sorter.sv
// tb_fitness_key_sorter: self-checking bench for the fitness key sorter; a stable sort
// predictor in a small scoreboard class checks every sorted transfer field by field
// depends on fks_pkg and the fitness_key_sorter rtl
`timescale 1ns / 100ps

module tb_fitness_key_sorter;

   localparam int KEY_W  = fks_pkg::KEY_W;
   localparam int TAG_W  = fks_pkg::TAG_W;
   localparam int DATA_W = fks_pkg::DATA_W;
   localparam int MAX_ELEMENTS = 32;
   localparam logic [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
   localparam logic [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};

   typedef struct {
      logic signed [KEY_W-1:0] key;
      logic [TAG_W-1:0]        tag;
   } element_type;

   typedef struct {
      logic signed [KEY_W-1:0] key;
      logic [TAG_W-1:0]        tag;
      bit                      final_res;
      bit                      overflow;
   } sorted_type;

   class sort_scoreboard;
      element_type held_elements[$];
      sorted_type  due_results[$];
      bit          dropped;
      int          errors;

      task report(string msg);
         if (errors < 100)
            $display("%0t mismatch: %s", $time, msg);
         errors++;
      endtask

      // loads one element; a closing transfer turns the set into its sorted run
      function void load_element(logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag, bit last);
         element_type el;
         element_type ordered[$];
         sorted_type  res;
         int          b;
         el.key = key;
         el.tag = tag;
         if (held_elements.size() < MAX_ELEMENTS)
            held_elements = {held_elements, el};
         else
            dropped = 1;
         if (!last)
            return;
         foreach (held_elements[a]) begin
            b = ordered.size();
            while (b > 0 && ordered[b-1].key > held_elements[a].key)
               b--;
            ordered.insert(b, held_elements[a]);
         end
         foreach (ordered[a]) begin
            res.key       = ordered[a].key;
            res.tag       = ordered[a].tag;
            res.final_res = (a == ordered.size() - 1);
            res.overflow  = dropped;
            due_results   = {due_results, res};
         end
         held_elements.delete();
         dropped = 0;
      endfunction

      task check_sorted(logic [DATA_W-1:0] data, bit last, bit ovf);
         sorted_type exp;
         if (due_results.size() == 0) begin
            report($sformatf("unexpected result key=%0d tag=%0d",
                             $signed(data[KEY_W-1:0]), data[DATA_W-1:KEY_W]));
            return;
         end
         exp = due_results.pop_front();
         if (data[KEY_W-1:0] !== exp.key)
            report($sformatf("sorted_key %0d, expected %0d",
                             $signed(data[KEY_W-1:0]), exp.key));
         if (data[DATA_W-1:KEY_W] !== exp.tag)
            report($sformatf("sorted_tag %0d, expected %0d", data[DATA_W-1:KEY_W], exp.tag));
         if (last !== exp.final_res)
            report($sformatf("final_res %0b, expected %0b", last, exp.final_res));
         if (ovf !== exp.overflow)
            report($sformatf("overflow %0b, expected %0b", ovf, exp.overflow));
      endtask
   endclass

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata;   // key, tag
   logic              req_tlast;   // is_last
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [DATA_W-1:0] rsp_tdata;   // sorted_key, sorted_tag
   logic              rsp_tlast;   // final_res
   logic              rsp_tuser;   // overflow

   sort_scoreboard sb;
   bit             quiet;

   fitness_key_sorter #(
      .MAX_ELEMENTS(MAX_ELEMENTS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.load_element(req_tdata[KEY_W-1:0], req_tdata[DATA_W-1:KEY_W], req_tlast);
         if (rsp_tvalid && rsp_tready)
            sb.check_sorted(rsp_tdata, rsp_tlast, rsp_tuser);
      end
   end

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_element(input logic [KEY_W-1:0] key, input logic [TAG_W-1:0] tag,
                               input bit last);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  = {tag, key};
      req_tlast  = last;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   function automatic logic [KEY_W-1:0] random_key(bit crowded);
      logic [KEY_W-1:0] r;
      r = KEY_W'({$urandom(), $urandom()});
      if (crowded)
         return KEY_W'($signed($urandom_range(0, 6)) - 3);
      case ($urandom_range(0, 5))
         0:       return $urandom_range(0, 1) ? KEY_MAX : KEY_MIN;
         1:       return {{(KEY_W-20){r[19]}}, r[19:0]};
         default: return r;
      endcase
   endfunction

   initial begin
      int stall;
      rsp_tready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 14);
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   initial begin
      #2_000_000;
      $display("** fitness_key_sorter: FAILED **");
      $finish;
   end

   initial begin
      int  sent;
      int  set_no;
      int  set_size;
      int  waited;
      bit  crowded;
      sb         = new();
      quiet      = 0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // extremes of key and tag, equal minimum keys
      send_element(KEY_MAX, 8'hFF, 0);
      send_element(KEY_MIN, 8'h00, 0);
      send_element('0, 8'h55, 0);
      send_element('1, 8'hAA, 0);
      send_element(48'h0000_0001_0000, 8'h01, 0);
      send_element(KEY_MIN, 8'h02, 0);
      send_element(KEY_MAX, 8'h03, 1);
      // single element set
      send_element(48'h5555_5555_5555, 8'h80, 1);
      // equal keys leave in load order
      for (int i = 0; i < 5; i++)
         send_element(48'd7, TAG_W'(10 + i), i == 4);
      // descending keys
      for (int i = 0; i < 5; i++)
         send_element(KEY_W'(100 - 40 * i), TAG_W'(20 + i), i == 4);

      // directed items above
      sent   = 18;
      set_no = 0;
      while (sent < 170) begin
         case (set_no)
            2:       set_size = MAX_ELEMENTS;
            5:       set_size = MAX_ELEMENTS + 1;
            8:       set_size = MAX_ELEMENTS + 4;
            default: set_size = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 40)
                                                             : $urandom_range(1, 8);
         endcase
         if (set_size > 170 - sent)
            set_size = 170 - sent;
         quiet   = ($urandom_range(0, 4) == 0);
         crowded = ($urandom_range(0, 2) == 0);
         for (int i = 0; i < set_size; i++)
            send_element(random_key(crowded), TAG_W'($urandom_range(0, 255)),
                         i == set_size - 1);
         sent += set_size;
         set_no++;
      end
      req_tvalid = 1'b0;
      quiet      = 0;

      for (waited = 0; waited < 20000 && sb.due_results.size() > 0; waited++)
         @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.due_results.size() > 0)
         sb.report($sformatf("%0d sorted results never arrived", sb.due_results.size()));
      if (sb.errors == 0)
         $display("** fitness_key_sorter: PASSED **");
      else
         $display("** fitness_key_sorter: FAILED **");
      $finish;
   end

endmodule

// File: fitness_key_sorter.f
rtl/fks_pkg.sv
rtl/fks_ctrl.sv
rtl/fks_datapath.sv
rtl/fitness_key_sorter.sv
rtl/fks_checker.sv
dv/tb_fitness_key_sorter.sv
